### rtl/core/flv_avc_to_annexb_converter_core_macros.svh
// Assertion helpers shared by the converter RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef FLV_AVC_TO_ANNEXB_CONVERTER_CORE_MACROS_SVH
`define FLV_AVC_TO_ANNEXB_CONVERTER_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset
`define FLVAC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define FLVAC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/flvac_pkg.sv
package flvac_pkg;

  // Parser phases, one-hot
  typedef enum logic [17:0] {
    PH_SIG_F     = 18'h00001,
    PH_SIG_L     = 18'h00002,
    PH_SIG_V     = 18'h00004,
    PH_HDR_SKIP  = 18'h00008,
    PH_TAG_HDR   = 18'h00010,
    PH_BACKPTR   = 18'h00020,
    PH_SKIP_BODY = 18'h00040,
    PH_V_FLAGS   = 18'h00080,
    PH_V_TYPE    = 18'h00100,
    PH_V_CTS_CFG = 18'h00200,
    PH_V_CTS_NAL = 18'h00400,
    PH_CFG_FIXED = 18'h00800,
    PH_CFG_LEN   = 18'h01000,
    PH_CFG_COUNT = 18'h02000,
    PH_CFG_SIZE  = 18'h04000,
    PH_CFG_DATA  = 18'h08000,
    PH_NAL_LEN   = 18'h10000,
    PH_NAL_DATA  = 18'h20000
  } phase_t;

  // What one input byte asks the back end to emit
  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_START    = 2'd1,
    OP_ERR      = 2'd2,
    OP_DATA_ERR = 2'd3
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data;
    logic [1:0] code;
  } cmd_t;

  // Error codes
  localparam logic [1:0] ERR_BAD_SIG  = 2'd0;
  localparam logic [1:0] ERR_LEN_SIZE = 2'd1;
  localparam logic [1:0] ERR_TRUNC    = 2'd2;

  // Format constants
  localparam logic [7:0] SIG_F          = 8'h46;
  localparam logic [7:0] SIG_L          = 8'h4C;
  localparam logic [7:0] SIG_V          = 8'h56;
  localparam logic [7:0] TAG_VIDEO      = 8'd9;
  localparam logic [7:0] SPS_COUNT_MASK = 8'h1F;
  localparam logic [1:0] LEN_SIZE_FOUR  = 2'h3;

  localparam logic [3:0] FILE_HDR_SKIP  = 4'd10;
  localparam logic [3:0] TAG_HDR_LEN    = 4'd11;
  localparam logic [3:0] BACKPTR_LEN    = 4'd4;
  localparam logic [3:0] CTS_LEN        = 4'd3;
  localparam logic [3:0] CFG_FIXED_LEN  = 4'd4;
  localparam logic [3:0] NAL_LEN_BYTES  = 4'd4;

  // Start code, first byte in the top bits
  localparam logic [31:0] START_CODE = 32'h0000_0001;

  // Command queue
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

endpackage

### rtl/core/flvac_parse.sv
`include "flv_avc_to_annexb_converter_core_macros.svh"

// Front end: walks the FLV structure one byte per beat and classifies it
module flvac_parse (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             beat,
  input  logic [7:0]       in_byte,
  output logic             cmd_valid,
  output flvac_pkg::cmd_t  cmd
);
  import flvac_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [3:0]  fidx_r, fidx_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [7:0]  tag_type_r, tag_type_nxt;
  logic [23:0] tag_left_r, tag_left_nxt;
  logic [31:0] nal_left_r, nal_left_nxt;
  logic [7:0]  sets_left_r, sets_left_nxt;
  logic        pps_r, pps_nxt;
  logic        halted_r, halted_nxt;

  logic        body;
  logic        err_v;
  logic [1:0]  err_code;
  logic        op_v;
  op_t         op;
  logic [3:0]  fidx_inc;
  logic [31:0] nal_dec;
  logic [7:0]  sets_dec;
  logic [15:0] size16;
  logic [31:0] acc_sh;
  phase_t      done_phase;
  logic        done_pps;

  assign fidx_inc = fidx_r + 4'd1;
  assign nal_dec  = nal_left_r - 32'd1;
  assign sets_dec = sets_left_r - 8'd1;
  assign size16   = {acc_r[7:0], in_byte};
  assign acc_sh   = {acc_r[23:0], in_byte};

  // Where the config walk goes when one parameter set is finished
  always_comb begin
    done_pps = pps_r;
    if (sets_dec != 8'd0) begin
      done_phase = PH_CFG_SIZE;
    end else if (!pps_r) begin
      done_phase = PH_CFG_COUNT;
      done_pps   = 1'b1;
    end else begin
      done_phase = PH_SKIP_BODY;
    end
  end

  // Byte parser
  always_comb begin
    phase_nxt     = phase_r;
    fidx_nxt      = fidx_r;
    acc_nxt       = acc_r;
    tag_type_nxt  = tag_type_r;
    tag_left_nxt  = tag_left_r;
    nal_left_nxt  = nal_left_r;
    sets_left_nxt = sets_left_r;
    pps_nxt       = pps_r;
    halted_nxt    = halted_r;
    body          = 1'b0;
    err_v         = 1'b0;
    err_code      = ERR_BAD_SIG;
    op_v          = 1'b0;
    op            = OP_DATA;

    if (!halted_r) begin
      // file and tag framing
      case (phase_r)
        PH_SIG_F: begin
          if (in_byte != SIG_F) err_v = 1'b1;
          else phase_nxt = PH_SIG_L;
        end
        PH_SIG_L: begin
          if (in_byte != SIG_L) err_v = 1'b1;
          else phase_nxt = PH_SIG_V;
        end
        PH_SIG_V: begin
          if (in_byte != SIG_V) begin
            err_v = 1'b1;
          end else begin
            phase_nxt = PH_HDR_SKIP;
            fidx_nxt  = 4'd0;
          end
        end
        PH_HDR_SKIP: begin
          fidx_nxt = fidx_inc;
          if (fidx_inc >= FILE_HDR_SKIP) begin
            phase_nxt = PH_TAG_HDR;
            fidx_nxt  = 4'd0;
          end
        end
        PH_TAG_HDR: begin
          if (fidx_r == 4'd0) tag_type_nxt = in_byte;
          else if (fidx_r == 4'd1) acc_nxt = {24'd0, in_byte};
          else if (fidx_r <= 4'd3) acc_nxt = acc_sh;
          fidx_nxt = fidx_inc;
          if (fidx_inc >= TAG_HDR_LEN) begin
            tag_left_nxt = acc_r[23:0];
            fidx_nxt     = 4'd0;
            if (acc_r[23:0] == 24'd0) phase_nxt = PH_BACKPTR;
            else if (tag_type_r == TAG_VIDEO) phase_nxt = PH_V_FLAGS;
            else phase_nxt = PH_SKIP_BODY;
          end
        end
        PH_BACKPTR: begin
          fidx_nxt = fidx_inc;
          if (fidx_inc >= BACKPTR_LEN) begin
            phase_nxt = PH_TAG_HDR;
            fidx_nxt  = 4'd0;
          end
        end
        default: body = 1'b1;
      endcase

      if (body) begin
        // tag body
        case (phase_r)
          PH_V_FLAGS: phase_nxt = PH_V_TYPE;
          PH_V_TYPE: begin
            phase_nxt = (in_byte == 8'd0) ? PH_V_CTS_CFG : PH_V_CTS_NAL;
            fidx_nxt  = 4'd0;
          end
          PH_V_CTS_CFG, PH_V_CTS_NAL: begin
            fidx_nxt = fidx_inc;
            if (fidx_inc >= CTS_LEN) begin
              phase_nxt = (phase_r == PH_V_CTS_CFG) ? PH_CFG_FIXED : PH_NAL_LEN;
              fidx_nxt  = 4'd0;
              acc_nxt   = 32'd0;
            end
          end
          PH_CFG_FIXED: begin
            fidx_nxt = fidx_inc;
            if (fidx_inc >= CFG_FIXED_LEN) begin
              phase_nxt = PH_CFG_LEN;
              fidx_nxt  = 4'd0;
            end
          end
          PH_CFG_LEN: begin
            if (in_byte[1:0] != LEN_SIZE_FOUR) begin
              err_v    = 1'b1;
              err_code = ERR_LEN_SIZE;
            end else begin
              pps_nxt   = 1'b0;
              phase_nxt = PH_CFG_COUNT;
            end
          end
          PH_CFG_COUNT: begin
            sets_left_nxt = pps_r ? in_byte : (in_byte & SPS_COUNT_MASK);
            fidx_nxt      = 4'd0;
            if (sets_left_nxt != 8'd0) phase_nxt = PH_CFG_SIZE;
            else if (!pps_r) pps_nxt = 1'b1;
            else phase_nxt = PH_SKIP_BODY;
          end
          PH_CFG_SIZE: begin
            if (fidx_r == 4'd0) begin
              acc_nxt  = {24'd0, in_byte};
              fidx_nxt = 4'd1;
            end else begin
              acc_nxt      = {16'd0, size16};
              op_v         = 1'b1;
              op           = OP_START;
              nal_left_nxt = {16'd0, size16};
              fidx_nxt     = 4'd0;
              if (size16 == 16'd0) begin
                sets_left_nxt = sets_dec;
                phase_nxt     = done_phase;
                pps_nxt       = done_pps;
              end else begin
                phase_nxt = PH_CFG_DATA;
              end
            end
          end
          PH_CFG_DATA: begin
            op_v         = 1'b1;
            nal_left_nxt = nal_dec;
            if (nal_dec == 32'd0) begin
              sets_left_nxt = sets_dec;
              fidx_nxt      = 4'd0;
              phase_nxt     = done_phase;
              pps_nxt       = done_pps;
            end
          end
          PH_NAL_LEN: begin
            acc_nxt  = acc_sh;
            fidx_nxt = fidx_inc;
            if (fidx_inc >= NAL_LEN_BYTES) begin
              op_v         = 1'b1;
              op           = OP_START;
              nal_left_nxt = acc_sh;
              fidx_nxt     = 4'd0;
              acc_nxt      = 32'd0;
              phase_nxt    = (acc_sh != 32'd0) ? PH_NAL_DATA : PH_NAL_LEN;
            end
          end
          PH_NAL_DATA: begin
            op_v         = 1'b1;
            nal_left_nxt = nal_dec;
            if (nal_dec == 32'd0) begin
              phase_nxt = PH_NAL_LEN;
              fidx_nxt  = 4'd0;
              acc_nxt   = 32'd0;
            end
          end
          default: ;
        endcase

        // tag boundary: a video tag cut before its packet type, or a coded-frame tag cut short, is a truncation
        tag_left_nxt = tag_left_r - 24'd1;
        if (!err_v && tag_left_nxt == 24'd0) begin
          if (phase_nxt == PH_V_TYPE || phase_nxt == PH_V_CTS_NAL ||
              (phase_nxt == PH_NAL_LEN && fidx_nxt != 4'd0) ||
              phase_nxt == PH_NAL_DATA) begin
            err_v    = 1'b1;
            err_code = ERR_TRUNC;
          end
          phase_nxt = PH_BACKPTR;
          fidx_nxt  = 4'd0;
        end
      end

      if (err_v) halted_nxt = 1'b1;
    end
  end

  // Command to the back end; an error drops a start code on the same byte
  always_comb begin
    cmd.data  = in_byte;
    cmd.code  = err_code;
    cmd_valid = op_v || err_v;
    if (err_v) cmd.op = (op_v && op == OP_DATA) ? OP_DATA_ERR : OP_ERR;
    else cmd.op = op;
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SIG_F;
      fidx_r      <= 4'd0;
      acc_r       <= 32'd0;
      tag_type_r  <= 8'd0;
      tag_left_r  <= 24'd0;
      nal_left_r  <= 32'd0;
      sets_left_r <= 8'd0;
      pps_r       <= 1'b0;
      halted_r    <= 1'b0;
    end else if (beat) begin
      phase_r     <= phase_nxt;
      fidx_r      <= fidx_nxt;
      acc_r       <= acc_nxt;
      tag_type_r  <= tag_type_nxt;
      tag_left_r  <= tag_left_nxt;
      nal_left_r  <= nal_left_nxt;
      sets_left_r <= sets_left_nxt;
      pps_r       <= pps_nxt;
      halted_r    <= halted_nxt;
    end
  end

  `FLVAC_ASSERT_NEXT(a_halt_sticky, halted_r, halted_r, "halt released without reset")
  `FLVAC_ASSERT_NEXT(a_err_halts, beat && err_v, halted_r, "error did not halt parser")

endmodule

### rtl/core/flvac_cmdq.sv
`include "flv_avc_to_annexb_converter_core_macros.svh"

// Short command queue between parser and emitter
module flvac_cmdq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  flvac_pkg::cmd_t  push_cmd,
  output logic             full,
  input  logic             pop,
  output logic             head_valid,
  output flvac_pkg::cmd_t  head_cmd
);
  import flvac_pkg::*;

  cmd_t                 q_r [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CMDQ_CW-1:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == CMDQ_CW'(CMDQ_DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = q_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + CMDQ_CW'(1);
    else if (pop && !push) cnt_nxt = cnt_r - CMDQ_CW'(1);
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + CMDQ_AW'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + CMDQ_AW'(1);
      cnt_r <= cnt_nxt;
    end
  end

  // Entries
  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= push_cmd;
  end

  `FLVAC_ASSERT_NOW(a_no_overflow, push, !full || pop, "push into full queue")
  `FLVAC_ASSERT_NOW(a_no_underflow, pop, head_valid, "pop from empty queue")

endmodule

### rtl/core/flvac_emit.sv
`include "flv_avc_to_annexb_converter_core_macros.svh"

// Back end: expands one command into its output beats
module flvac_emit (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  flvac_pkg::cmd_t  head_cmd,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             out_is_error,
  output logic [1:0]       out_error_code,
  output logic             out_last_in_run
);
  import flvac_pkg::*;

  logic [1:0] beat_idx_r, beat_idx_nxt;
  logic       out_beat;

  assign out_valid = head_valid;
  assign out_beat  = out_valid && out_ready;
  assign pop       = out_beat && out_last_in_run;

  // Beat decode
  always_comb begin
    out_byte        = 8'd0;
    out_is_error    = 1'b0;
    out_error_code  = ERR_BAD_SIG;
    out_last_in_run = 1'b1;
    case (head_cmd.op)
      OP_DATA: out_byte = head_cmd.data;
      OP_START: begin
        out_byte        = START_CODE[{~beat_idx_r, 3'b000} +: 8];
        out_last_in_run = (beat_idx_r == 2'd3);
      end
      OP_ERR: begin
        out_is_error   = 1'b1;
        out_error_code = head_cmd.code;
      end
      OP_DATA_ERR: begin
        if (beat_idx_r == 2'd0) begin
          out_byte        = head_cmd.data;
          out_last_in_run = 1'b0;
        end else begin
          out_is_error   = 1'b1;
          out_error_code = head_cmd.code;
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    beat_idx_nxt = beat_idx_r;
    if (out_beat) beat_idx_nxt = out_last_in_run ? 2'd0 : beat_idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) beat_idx_r <= 2'd0;
    else beat_idx_r <= beat_idx_nxt;
  end

  `FLVAC_ASSERT_NOW(a_idle_idx, !head_valid, beat_idx_r == 2'd0, "beat index off while idle")

endmodule

### rtl/core/flv_avc_to_annexb_converter_core.sv
// FLV (AVC) to Annex B converter.
// Throughput: one input byte per cycle; a start code takes 4 output beats and an
//   error after data 2, so input stalls only when the 4-entry command queue fills.
// Output: each accepted byte's command is registered in the command queue before its beats.
// Reset: synchronous, active low; parser returns to the signature check, queue
//   empties, halt clears. No clearing pass, ready right after reset.
module flv_avc_to_annexb_converter_core (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_is_error,
  output logic [1:0] out_error_code,
  output logic       out_last_in_run
);
  import flvac_pkg::*;

  logic in_beat;
  logic cmd_valid;
  cmd_t cmd;
  logic q_full;
  logic q_pop;
  logic head_valid;
  cmd_t head_cmd;

  assign in_ready = !q_full;
  assign in_beat  = in_valid && in_ready;

  flvac_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat      (in_beat),
    .in_byte   (in_byte),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  flvac_cmdq u_cmdq (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (in_beat && cmd_valid),
    .push_cmd   (cmd),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  flvac_emit u_emit (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (head_valid),
    .head_cmd        (head_cmd),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_is_error    (out_is_error),
    .out_error_code  (out_error_code),
    .out_last_in_run (out_last_in_run)
  );

endmodule

### sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import flvac_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam logic [31:0] START_WORD = 32'h0000_0001;
  // version, flags, header offset, first back-pointer
  localparam logic [79:0] FILE_HDR_TAIL = 80'h01_FF_00000009_FF00AA55;

  typedef struct packed {
    logic [7:0] data;
    logic       is_error;
    logic [1:0] code;
    logic       last;
  } annexb_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_is_error;
  logic [1:0] out_error_code;
  logic       out_last_in_run;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int bytes_sent = 0;
  int mismatches = 0;
  int cycle_cnt = 0;

  annexb_beat_t annexb_q[$];
  logic [7:0]   body_q[$];

  // Parser state mirror
  phase_t       ph;
  logic [3:0]   fld_idx;
  logic [31:0]  fld_acc;
  logic [7:0]   tag_kind;
  logic [23:0]  tag_left;
  logic [31:0]  nal_left;
  logic [7:0]   sets_left;
  logic         pps_section;
  logic         halted;
  annexb_beat_t step_res[4];
  int           step_n;

  flv_avc_to_annexb_converter_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_is_error   (out_is_error),
    .out_error_code (out_error_code),
    .out_last_in_run(out_last_in_run)
  );

  always #6 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when requested
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Annex B prediction
  // ---------------------------------------------------------------------------

  task reset_parser;
    ph          = PH_SIG_F;
    fld_idx     = '0;
    fld_acc     = '0;
    tag_kind    = '0;
    tag_left    = '0;
    nal_left    = '0;
    sets_left   = '0;
    pps_section = 1'b0;
    halted      = 1'b0;
  endtask

  // At most four beats per input byte; extra beats are dropped
  task add_beat(input logic [7:0] d);
    if (step_n < 4) begin
      step_res[step_n] = {d, 1'b0, 2'd0, 1'b0};
      step_n++;
    end
  endtask

  task add_start_code;
    for (int k = 0; k < 4; k++) add_beat(START_WORD[31 - 8 * k -: 8]);
  endtask

  // One SPS or PPS finished: next set, PPS section, or skip the rest
  task finish_param_set;
    sets_left = sets_left - 8'd1;
    fld_idx   = '0;
    if (sets_left != 0) ph = PH_CFG_SIZE;
    else if (!pps_section) begin
      pps_section = 1'b1;
      ph = PH_CFG_COUNT;
    end else ph = PH_SKIP_BODY;
  endtask

  task parse_flv_byte(input logic [7:0] b);
    logic       err;
    logic [1:0] err_code;
    logic       in_body;
    err      = 1'b0;
    err_code = ERR_BAD_SIG;
    in_body  = 1'b0;
    step_n   = 0;
    if (!halted) begin
      // file header, tag header and back-pointer
      case (ph)
        PH_SIG_F: if (b != SIG_F) err = 1'b1; else ph = PH_SIG_L;
        PH_SIG_L: if (b != SIG_L) err = 1'b1; else ph = PH_SIG_V;
        PH_SIG_V: begin
          if (b != SIG_V) err = 1'b1;
          else begin
            ph = PH_HDR_SKIP;
            fld_idx = '0;
          end
        end
        PH_HDR_SKIP: begin
          fld_idx = fld_idx + 4'd1;
          if (fld_idx >= FILE_HDR_SKIP) begin
            ph = PH_TAG_HDR;
            fld_idx = '0;
          end
        end
        PH_TAG_HDR: begin
          if (fld_idx == 0) tag_kind = b;
          else if (fld_idx == 1) fld_acc = {24'h0, b};
          else if (fld_idx <= 3) fld_acc = {fld_acc[23:0], b};
          fld_idx = fld_idx + 4'd1;
          if (fld_idx >= TAG_HDR_LEN) begin
            tag_left = fld_acc[23:0];
            fld_idx  = '0;
            if (tag_left == 0) ph = PH_BACKPTR;
            else if (tag_kind == TAG_VIDEO) ph = PH_V_FLAGS;
            else ph = PH_SKIP_BODY;
          end
        end
        PH_BACKPTR: begin
          fld_idx = fld_idx + 4'd1;
          if (fld_idx >= BACKPTR_LEN) begin
            ph = PH_TAG_HDR;
            fld_idx = '0;
          end
        end
        default: in_body = 1'b1;
      endcase

      // tag body
      if (in_body) begin
        case (ph)
          PH_V_FLAGS: ph = PH_V_TYPE;
          PH_V_TYPE: begin
            ph = (b == 8'h00) ? PH_V_CTS_CFG : PH_V_CTS_NAL;
            fld_idx = '0;
          end
          PH_V_CTS_CFG, PH_V_CTS_NAL: begin
            fld_idx = fld_idx + 4'd1;
            if (fld_idx >= CTS_LEN) begin
              ph = (ph == PH_V_CTS_CFG) ? PH_CFG_FIXED : PH_NAL_LEN;
              fld_idx = '0;
              fld_acc = '0;
            end
          end
          PH_CFG_FIXED: begin
            fld_idx = fld_idx + 4'd1;
            if (fld_idx >= CFG_FIXED_LEN) begin
              ph = PH_CFG_LEN;
              fld_idx = '0;
            end
          end
          PH_CFG_LEN: begin
            if (b[1:0] != LEN_SIZE_FOUR) begin
              err = 1'b1;
              err_code = ERR_LEN_SIZE;
            end else begin
              pps_section = 1'b0;
              ph = PH_CFG_COUNT;
            end
          end
          PH_CFG_COUNT: begin
            sets_left = pps_section ? b : (b & SPS_COUNT_MASK);
            fld_idx = '0;
            if (sets_left != 0) ph = PH_CFG_SIZE;
            else if (!pps_section) pps_section = 1'b1;
            else ph = PH_SKIP_BODY;
          end
          PH_CFG_SIZE: begin
            if (fld_idx == 0) begin
              fld_acc = {24'h0, b};
              fld_idx = 4'd1;
            end else begin
              fld_acc = {16'h0, fld_acc[7:0], b};
              add_start_code();
              nal_left = fld_acc;
              fld_idx = '0;
              if (nal_left == 0) finish_param_set();
              else ph = PH_CFG_DATA;
            end
          end
          PH_CFG_DATA: begin
            add_beat(b);
            nal_left = nal_left - 32'd1;
            if (nal_left == 0) finish_param_set();
          end
          PH_NAL_LEN: begin
            fld_acc = {fld_acc[23:0], b};
            fld_idx = fld_idx + 4'd1;
            if (fld_idx >= NAL_LEN_BYTES) begin
              add_start_code();
              nal_left = fld_acc;
              fld_idx = '0;
              fld_acc = '0;
              ph = (nal_left != 0) ? PH_NAL_DATA : PH_NAL_LEN;
            end
          end
          PH_NAL_DATA: begin
            add_beat(b);
            nal_left = nal_left - 32'd1;
            if (nal_left == 0) begin
              ph = PH_NAL_LEN;
              fld_idx = '0;
              fld_acc = '0;
            end
          end
          default: ;
        endcase

        // tag boundary: video tag cut before its packet type, or coded-frame tag cut short, is an error
        tag_left = tag_left - 24'd1;
        if (!err && tag_left == 0) begin
          if (ph == PH_V_TYPE || ph == PH_V_CTS_NAL || ph == PH_NAL_DATA ||
              (ph == PH_NAL_LEN && fld_idx != 0)) begin
            err = 1'b1;
            err_code = ERR_TRUNC;
          end
          ph = PH_BACKPTR;
          fld_idx = '0;
        end
      end

      // error beat follows the data; a full start code gives way to it
      if (err) begin
        if (step_n >= 4) step_n = 0;
        step_res[step_n] = {8'h00, 1'b1, err_code, 1'b0};
        step_n++;
        halted = 1'b1;
      end
      if (step_n > 0) step_res[step_n - 1].last = 1'b1;
      for (int k = 0; k < step_n; k++) annexb_q.push_back(step_res[k]);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output check
  // ---------------------------------------------------------------------------

  task note_mismatch(input annexb_beat_t want, input annexb_beat_t got, input bit stray);
    mismatches++;
    if (mismatches <= 10) begin
      if (stray)
        $display("[%0t] unexpected beat: byte %02h err %0b code %0d last %0b",
                 $time, got.data, got.is_error, got.code, got.last);
      else begin
        $display("[%0t] beat mismatch: want byte %02h err %0b code %0d last %0b",
                 $time, want.data, want.is_error, want.code, want.last);
        $display("[%0t]                 got byte %02h err %0b code %0d last %0b",
                 $time, got.data, got.is_error, got.code, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    annexb_beat_t got;
    annexb_beat_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_byte, out_is_error, out_error_code, out_last_in_run};
      if (annexb_q.size() == 0) begin
        note_mismatch(got, got, 1'b1);
      end else begin
        want = annexb_q.pop_front();
        if (got !== want) note_mismatch(want, got, 1'b0);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic logic [7:0] rand_byte();
    return 8'($urandom);
  endfunction

  // One input beat; random gaps before it, valid held until accepted
  task send_byte(input logic [7:0] b);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_flv_byte(b);
    bytes_sent++;
  endtask

  task pause_until_drained;
    in_valid <= 1'b0;
    @(posedge clk);
    while (annexb_q.size() != 0) @(posedge clk);
  endtask

  task send_tag_header(input logic [7:0] kind, input logic [23:0] size);
    send_byte(kind);
    send_byte(size[23:16]);
    send_byte(size[15:8]);
    send_byte(size[7:0]);
    // timestamp, extension, stream id
    repeat (TAG_HDR_LEN - 4) send_byte(rand_byte());
  endtask

  task send_tag(input logic [7:0] kind);
    send_tag_header(kind, 24'(body_q.size()));
    foreach (body_q[i]) send_byte(body_q[i]);
    repeat (BACKPTR_LEN) send_byte(rand_byte());
  endtask

  task open_video_body(input logic [7:0] avc_type);
    body_q.delete();
    body_q.push_back(rand_byte());
    body_q.push_back(avc_type);
    repeat (CTS_LEN) body_q.push_back(rand_byte());
  endtask

  task add_nal(input logic [31:0] len, input int payload);
    for (int s = 24; s >= 0; s -= 8) body_q.push_back(len[s +: 8]);
    repeat (payload) body_q.push_back(rand_byte());
  endtask

  task add_param_set(input logic [15:0] size, input int payload);
    body_q.push_back(size[15:8]);
    body_q.push_back(size[7:0]);
    repeat (payload) body_q.push_back(rand_byte());
  endtask

  task open_config_body(input logic [7:0] len_byte);
    open_video_body(8'h00);
    repeat (CFG_FIXED_LEN) body_q.push_back(rand_byte());
    body_q.push_back(len_byte);
  endtask

  // Well-formed decoder config, sometimes cut short or padded
  task make_config_body;
    int n_sets;
    int sz;
    int cut;
    open_config_body(rand_byte() | {6'h0, LEN_SIZE_FOUR});
    n_sets = $urandom_range(3);
    body_q.push_back((rand_byte() & ~SPS_COUNT_MASK) | 8'(n_sets));
    repeat (n_sets) begin
      sz = $urandom_range(8);
      add_param_set(16'(sz), sz);
    end
    n_sets = $urandom_range(2);
    body_q.push_back(8'(n_sets));
    repeat (n_sets) begin
      sz = $urandom_range(8);
      add_param_set(16'(sz), sz);
    end
    repeat ($urandom_range(2)) body_q.push_back(rand_byte());
    if ($urandom_range(3) == 0) begin
      cut = $urandom_range(body_q.size(), 2);
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
  endtask

  // Well-formed coded-frame tag: whole NAL units only
  task make_nal_body;
    int len;
    open_video_body(8'($urandom_range(255, 1)));
    repeat ($urandom_range(3)) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(40, 11) : $urandom_range(10);
      add_nal(32'(len), len);
    end
  endtask

  task make_noise_body;
    body_q.delete();
    repeat ($urandom_range(8)) body_q.push_back(rand_byte());
  endtask

  function automatic logic [7:0] other_tag_kind();
    logic [7:0] kind;
    kind = rand_byte();
    if (kind == TAG_VIDEO) kind = 8'h08;
    return kind;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task test_file_header;
    send_byte(SIG_F);
    send_byte(SIG_L);
    send_byte(SIG_V);
    for (int i = 0; i < 10; i++) send_byte(FILE_HDR_TAIL[79 - 8 * i -: 8]);
  endtask

  task test_zero_length_tags;
    body_q.delete();
    send_tag(TAG_VIDEO);
    send_tag(8'h12);
    send_tag(8'hFF);
  endtask

  // Types one bit away from video; body would yield output if parsed
  task test_tag_type_filter;
    logic [7:0] kinds[3];
    kinds = '{8'h89, 8'h08, 8'h19};
    foreach (kinds[i]) begin
      open_video_body(8'h01);
      add_nal(32'd1, 1);
      send_tag(kinds[i]);
    end
  endtask

  task test_config_records;
    // one empty SPS behind a count with reserved bits set, one PPS, padding
    open_config_body(8'hFF);
    body_q.push_back(8'hE1);
    add_param_set(16'd0, 0);
    body_q.push_back(8'h01);
    body_q.push_back(8'h00);
    body_q.push_back(8'h02);
    body_q.push_back(8'hFF);
    body_q.push_back(8'h00);
    body_q.push_back(8'hFF);
    body_q.push_back(8'h00);
    send_tag(TAG_VIDEO);
    // no sets at all
    open_config_body(8'h03);
    body_q.push_back(8'hE0);
    body_q.push_back(8'h00);
    send_tag(TAG_VIDEO);
    // two of each
    open_config_body(8'h07);
    body_q.push_back(8'h02);
    repeat (2) add_param_set(16'd3, 3);
    body_q.push_back(8'h02);
    repeat (2) add_param_set(16'd1, 1);
    send_tag(TAG_VIDEO);
  endtask

  task test_nal_units;
    // empty NAL then a short one, ending exactly at the tag boundary
    open_video_body(8'h01);
    add_nal(32'd0, 0);
    add_nal(32'd3, 3);
    send_tag(TAG_VIDEO);
    // header only, no NAL units
    open_video_body(8'hFF);
    send_tag(TAG_VIDEO);
  endtask

  // Cut config records end quietly at the tag boundary
  task test_truncated_config;
    open_config_body(8'hFF);
    body_q.push_back(8'h01);
    add_param_set(16'hFFFF, 3);
    send_tag(TAG_VIDEO);
    open_config_body(8'hFF);
    body_q.push_back(8'h00);
    body_q.push_back(8'h80);
    body_q.push_back(8'h00);
    send_tag(TAG_VIDEO);
    open_video_body(8'h00);
    repeat (CTS_LEN) void'(body_q.pop_back());
    send_tag(TAG_VIDEO);
  endtask

  task test_random_stream(input int n_bytes);
    int first;
    int pick;
    first = bytes_sent;
    while (bytes_sent - first < n_bytes) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        make_nal_body();
        send_tag(TAG_VIDEO);
      end else if (pick < 72) begin
        make_config_body();
        send_tag(TAG_VIDEO);
      end else if (pick < 92) begin
        make_noise_body();
        send_tag(other_tag_kind());
      end else begin
        body_q.delete();
        send_tag(pick[0] ? TAG_VIDEO : rand_byte());
      end
    end
  endtask

  task test_output_stall;
    hold_left = 300;
    open_video_body(8'h01);
    add_nal(32'd16, 16);
    add_nal(32'd0, 0);
    add_nal(32'd0, 0);
    send_tag(TAG_VIDEO);
    pause_until_drained();
    make_nal_body();
    send_tag(TAG_VIDEO);
  endtask

  // One error per run since reset is applied only once; bytes after it are dropped
  task test_halt_on_error;
    case ($urandom_range(5))
      0: begin
        open_config_body((rand_byte() & 8'hFC) | 8'($urandom_range(2)));
        body_q.push_back(8'hE1);
        add_param_set(16'd2, 2);
      end
      1: begin
        body_q.delete();
        body_q.push_back(rand_byte());
      end
      2: begin
        open_video_body(8'($urandom_range(255, 1)));
        repeat ($urandom_range(3, 1)) void'(body_q.pop_back());
      end
      3: begin
        open_video_body(8'($urandom_range(255, 1)));
        repeat ($urandom_range(3, 1)) body_q.push_back(rand_byte());
      end
      4: begin
        // payload still owed: data beat then error beat
        open_video_body(8'($urandom_range(255, 1)));
        add_nal({1'b1, 31'($urandom)}, $urandom_range(3, 1));
      end
      default: begin
        // length completes on the last byte: start code dropped for the error
        open_video_body(8'($urandom_range(255, 1)));
        add_nal($urandom | 32'h1, 0);
      end
    endcase
    send_tag(TAG_VIDEO);
    repeat (6) send_byte(rand_byte());
  endtask

  initial begin
    reset_parser();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 8;
    recv_idle_pct = 64;
    test_file_header();
    test_zero_length_tags();
    test_tag_type_filter();
    test_config_records();
    test_nal_units();
    test_truncated_config();

    send_idle_pct = 64;
    recv_idle_pct = 8;
    test_random_stream(30);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_output_stall();
    test_halt_on_error();

    // drain, then watch for stray beats
    in_valid <= 1'b0;
    @(posedge clk);
    while (annexb_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && annexb_q.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
